>>> src/sequential_list_engine_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sequential list engine.
// Each macro checks a property on the rising clock edge, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_UNIT_ASSERT_SVH

// The condition holds at every edge outside reset.
`define SLE_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequence holds in the same cycle as the antecedent.
`define SLE_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequence holds in the cycle after the antecedent.
`define SLE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/sle_pkg.sv
// ---------------------------------------------------------------------------
// sle_pkg
// Sizes, codes and beat types shared by the sequential list engine.
// ---------------------------------------------------------------------------
package sle_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int POS_W = 7;
  // Wide enough to compare a position against count + 1 without overflow.
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [CMP_W-1:0]      cmp_t;

  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_FIND    = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_REVERSE = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic [2:0]         operation;
    logic [POS_W-1:0]   position;
    logic signed [31:0] item_value;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] result_value;
    logic [5:0]         found_index;
    logic [6:0]         entry_count;
    logic               is_empty;
  } result_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    value_t wdata;
    logic   re;
    idx_t   raddr;
  } mem_req_t;

  // The input value is sign-extended, then kept in its low VALUE_BITS bits.
  function automatic value_t widen_value(logic signed [31:0] v);
    return VALUE_BITS'(v);
  endfunction

endpackage

>>> src/sle_ram.sv
// ---------------------------------------------------------------------------
// sle_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/sle_seq.sv
// ---------------------------------------------------------------------------
// sle_seq
// Sequencer that walks the list store one entry per cycle for each operation.
// ---------------------------------------------------------------------------
module sle_seq import sle_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_stall,
  input  item_t    item,
  output logic     res_valid,
  input  logic     res_stall,
  output result_t  res,
  output mem_req_t mem,
  input  value_t   rdata
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_INS  = 8'b0000_0010,
    S_PUT  = 8'b0000_0100,
    S_REM  = 8'b0000_1000,
    S_FIND = 8'b0001_0000,
    S_READ = 8'b0010_0000,
    S_REV  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t      state, state_next;
  cnt_t        count, count_next;
  idx_t        pos_m1, pos_m1_next;
  value_t      val, val_next;
  idx_t        rd_ptr, rd_ptr_next;
  cnt_t        rd_left, rd_left_next;
  logic        pend, pend_next;
  idx_t        pend_addr, pend_addr_next;
  idx_t        lo, lo_next;
  idx_t        hi, hi_next;
  value_t      tmp, tmp_next;
  logic        phase, phase_next;
  logic        wb, wb_next;
  logic [1:0]  status, status_next;
  logic [31:0] rval, rval_next;
  logic [5:0]  fidx, fidx_next;

  logic walk;
  cmp_t posw, cntw;

  assign posw = cmp_t'(item.position);
  assign cntw = cmp_t'(count);

  assign item_stall = (state != S_IDLE);
  assign res_valid  = (state == S_DONE);

  always_comb begin
    res.status       = status;
    res.result_value = rval;
    res.found_index  = fidx;
    res.entry_count  = 7'(count);
    res.is_empty     = (count == '0);
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    pos_m1_next    = pos_m1;
    val_next       = val;
    rd_ptr_next    = rd_ptr;
    rd_left_next   = rd_left;
    pend_next      = 1'b0;
    pend_addr_next = pend_addr;
    lo_next        = lo;
    hi_next        = hi;
    tmp_next       = tmp;
    phase_next     = phase;
    wb_next        = wb;
    status_next    = status;
    rval_next      = rval;
    fidx_next      = fidx;
    walk           = 1'b0;
    mem            = '0;

    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          val_next     = widen_value(item.item_value);
          pos_m1_next  = idx_t'(posw - cmp_t'(1));
          status_next  = ST_OK;
          rval_next    = '0;
          fidx_next    = '0;
          rd_left_next = '0;
          state_next   = S_DONE;
          unique case (item.operation)
            OP_INSERT: begin
              if (posw == '0 || posw > cntw + cmp_t'(1)) begin
                status_next = ST_RANGE;
              end else if (count == cnt_t'(CAPACITY)) begin
                status_next = ST_FULL;
              end else begin
                rd_ptr_next  = idx_t'(cntw - cmp_t'(1));
                rd_left_next = cnt_t'(cntw - posw + cmp_t'(1));
                state_next   = S_INS;
              end
            end
            OP_REMOVE: begin
              if (posw == '0 || posw > cntw) begin
                status_next = ST_RANGE;
              end else begin
                rd_ptr_next  = idx_t'(posw - cmp_t'(1));
                rd_left_next = cnt_t'(cntw - posw + cmp_t'(1));
                state_next   = S_REM;
              end
            end
            OP_FIND: begin
              if (count == '0) begin
                status_next = ST_MISSING;
              end else begin
                rd_ptr_next  = '0;
                rd_left_next = count;
                state_next   = S_FIND;
              end
            end
            OP_READ: begin
              if (posw < cntw) begin
                rd_ptr_next  = idx_t'(posw);
                rd_left_next = cnt_t'(1);
                state_next   = S_READ;
              end else begin
                status_next = ST_RANGE;
                rval_next   = '1;
              end
            end
            OP_REVERSE: begin
              if (count > cnt_t'(1)) begin
                lo_next    = '0;
                hi_next    = idx_t'(cntw - cmp_t'(1));
                phase_next = 1'b0;
                wb_next    = 1'b0;
                state_next = S_REV;
              end
            end
            default: begin
              // Undefined operation codes leave the list untouched.
            end
          endcase
        end
      end

      S_INS: begin
        // Entries move up by one place, walking down from the top.
        walk = 1'b1;
        if (pend) begin
          mem.we    = 1'b1;
          mem.waddr = pend_addr + idx_t'(1);
          mem.wdata = rdata;
        end
        if (rd_left == '0) begin
          state_next = S_PUT;
        end
      end

      S_PUT: begin
        mem.we     = 1'b1;
        mem.waddr  = pos_m1;
        mem.wdata  = val;
        count_next = count + cnt_t'(1);
        state_next = S_DONE;
      end

      S_REM: begin
        // The first entry read is the removed one; the rest move down.
        walk = 1'b1;
        if (pend) begin
          if (pend_addr == pos_m1) begin
            rval_next = 32'(rdata);
          end else begin
            mem.we    = 1'b1;
            mem.waddr = pend_addr - idx_t'(1);
            mem.wdata = rdata;
          end
        end
        if (rd_left == '0) begin
          count_next = count - cnt_t'(1);
          state_next = S_DONE;
        end
      end

      S_FIND: begin
        walk = 1'b1;
        if (pend && rdata == val) begin
          fidx_next  = 6'(pend_addr);
          state_next = S_DONE;
        end else if (rd_left == '0) begin
          status_next = ST_MISSING;
          state_next  = S_DONE;
        end
      end

      S_READ: begin
        walk = 1'b1;
        if (rd_left == '0) begin
          rval_next  = 32'(rdata);
          state_next = S_DONE;
        end
      end

      S_REV: begin
        // The writes of one swapped pair overlap the reads of the next, so read
        // and write addresses never coincide.
        if (!phase) begin
          if (wb) begin
            mem.we    = 1'b1;
            mem.waddr = lo - idx_t'(1);
            mem.wdata = rdata;
          end
          if (lo < hi) begin
            mem.re    = 1'b1;
            mem.raddr = lo;
          end
          phase_next = 1'b1;
        end else begin
          if (wb) begin
            mem.we    = 1'b1;
            mem.waddr = hi + idx_t'(1);
            mem.wdata = tmp;
          end
          phase_next = 1'b0;
          if (lo < hi) begin
            mem.re    = 1'b1;
            mem.raddr = hi;
            tmp_next  = rdata;
            lo_next   = lo + idx_t'(1);
            hi_next   = hi - idx_t'(1);
            wb_next   = 1'b1;
          end else begin
            state_next = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!res_stall) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (walk && rd_left != '0) begin
      mem.re         = 1'b1;
      mem.raddr      = rd_ptr;
      rd_left_next   = rd_left - cnt_t'(1);
      rd_ptr_next    = (state == S_INS) ? rd_ptr - idx_t'(1) : rd_ptr + idx_t'(1);
      pend_next      = 1'b1;
      pend_addr_next = rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      wb    <= 1'b0;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      wb    <= wb_next;
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    pos_m1    <= pos_m1_next;
    val       <= val_next;
    rd_ptr    <= rd_ptr_next;
    rd_left   <= rd_left_next;
    pend_addr <= pend_addr_next;
    lo        <= lo_next;
    hi        <= hi_next;
    tmp       <= tmp_next;
    status    <= status_next;
    rval      <= rval_next;
    fidx      <= fidx_next;
  end

endmodule

>>> src/sequential_list_engine_unit.sv
// ---------------------------------------------------------------------------
// sequential_list_engine_unit
// Ordered list of signed values in one RAM, with insert, remove, find, read
// and reverse operations.
//
//   Channel   Handshake                 Beat
//   item      item_valid / item_stall   item_t: operation, position, value
//   result    result_valid / result_stall  result_t: one beat per item
//
// An item is taken, then walked through the single-port-read RAM one entry
// per cycle; the single RAM read port sets this pace. Reverse swaps the
// entries in pairs, from both ends of the list towards the middle.
// Reset clears count and control state; the store needs no clearing pass.
// A result waiting in the output register does not block the next item.
// ---------------------------------------------------------------------------
module sequential_list_engine_unit import sle_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  `include "sequential_list_engine_unit_assert.svh"

  logic     res_valid;
  logic     res_stall;
  logic     res_take;
  result_t  res;
  mem_req_t mem;
  value_t   rdata;

  sle_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .mem        (mem),
    .rdata      (rdata)
  );

  sle_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  // The output register takes a new beat whenever it is empty or draining.
  assign res_stall = result_valid && result_stall;
  assign res_take  = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      result <= res;
    end
  end

  `SLE_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall,
    "engine did not start work on an accepted item")
  `SLE_ASSERT_IMPLY(a_no_same_entry, mem.we && mem.re, mem.waddr != mem.raddr,
    "RAM read and write hit the same entry in one cycle")
  `SLE_ASSERT_IMPLY(a_full_count, result_valid && result.status == ST_FULL,
    result.entry_count == 7'(CAPACITY), "full status with a list that is not full")

endmodule

>>> sim/list_engine_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// list_engine_checker
// Watches both channels of the sequential list engine. Every item beat that
// is taken is applied to a local copy of the list, and the result that it
// should produce is queued. Every result beat that is taken is compared,
// field by field, with the oldest queued result.
// ---------------------------------------------------------------------------
module list_engine_checker import sle_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_stall,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      fail_count,
  output int      pending,
  output int      list_len,
  output int      full_count
);

  value_t  list_store [CAPACITY];
  result_t expected_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    list_len   = 0;
    full_count = 0;
  end

  // Applies one operation to the local list and returns the result it owes.
  function automatic result_t apply_list_op(item_t beat);
    result_t r;
    value_t  v;
    value_t  t;
    int      p;
    int      i;
    int      lo;
    int      hi;
    r = '0;
    r.status = ST_OK;
    v = value_t'(beat.item_value);
    p = beat.position;
    case (beat.operation)
      OP_INSERT: begin
        // The position is checked before the free space.
        if (p < 1 || p > list_len + 1) begin
          r.status = ST_RANGE;
        end else if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_len; i > p - 1; i--) list_store[i] = list_store[i - 1];
          list_store[p - 1] = v;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (p < 1 || p > list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.result_value = 32'(list_store[p - 1]);
          for (i = p; i < list_len; i++) list_store[i - 1] = list_store[i];
          list_len--;
        end
      end
      OP_FIND: begin
        r.status = ST_MISSING;
        for (i = 0; i < list_len; i++) begin
          if (list_store[i] == v) begin
            r.status = ST_OK;
            r.found_index = 6'(i);
            break;
          end
        end
      end
      OP_READ: begin
        if (p < list_len) begin
          r.result_value = 32'(list_store[p]);
        end else begin
          r.status = ST_RANGE;
          r.result_value = '1;
        end
      end
      OP_REVERSE: begin
        lo = 0;
        hi = list_len;
        while (hi > lo + 1) begin
          hi--;
          t = list_store[lo];
          list_store[lo] = list_store[hi];
          list_store[hi] = t;
          lo++;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = 7'(list_len);
    r.is_empty = (list_len == 0);
    return r;
  endfunction

  task automatic check_field(input string field_name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
               $time, field_name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      list_len = 0;
      expected_results.delete();
    end else begin
      if (item_valid && !item_stall) begin
        want = apply_list_op(item);
        if (want.status == ST_FULL) full_count++;
        expected_results.push_back(want);
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing outstanding, expected no beat, got 0x%0h",
                   $time, result);
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, result.status);
          check_field("result_value", want.result_value, result.result_value);
          check_field("found_index", want.found_index, result.found_index);
          check_field("entry_count", want.entry_count, result.entry_count);
          check_field("is_empty", want.is_empty, result.is_empty);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives the sequential list engine with a short directed sequence, then with
// random operations that fill the list to capacity and drain it again, with
// random gaps on the item side and random stalls on the result side.
// ---------------------------------------------------------------------------
module testbench;
  import sle_pkg::*;

  localparam int POS_MAX = 2 ** POS_W - 1;
  localparam int RANDOM_ITEMS = 1800;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER = 300;
  localparam logic [2:0] OP_SPARE_FIRST = OP_REVERSE + 3'd1;
  localparam logic [2:0] OP_SPARE_LAST = 3'd7;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  int fail_count;
  int pending;
  int list_len;
  int full_count;

  int items_sent = 0;
  int calm_left = 0;
  int op_tally [8];

  sequential_list_engine_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  list_engine_checker list_monitor (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending),
    .list_len     (list_len),
    .full_count   (full_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Gap before the next item beat: mostly none or short, now and then long,
  // and occasionally a long stretch of back-to-back beats.
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) calm_left = $urandom_range(40, 120);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Values come partly from a small pool so that finds hit often.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return -32'sd1;
      3: return 32'sd0;
      4, 5, 6: return $signed(32'($urandom_range(0, 15)) * 32'h1001_0011);
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic [POS_W-1:0] bad_position(int first_bad);
    if (first_bad > POS_MAX || $urandom_range(0, 2) == 0) return '0;
    return POS_W'($urandom_range(first_bad, POS_MAX));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input item_t beat);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= beat;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    items_sent++;
    op_tally[beat.operation]++;
    @(negedge clk);
  endtask

  task automatic send_op(input logic [2:0] op, input int pos,
                         input logic signed [31:0] val);
    item_t beat;
    beat.operation = op;
    beat.position = POS_W'(pos);
    beat.item_value = val;
    send_item(beat);
  endtask

  // Result side: random stalls, plus one long hold-off that backs up the block.
  initial begin
    int  stall_for;
    int  free_for;
    int  r;
    bit  held;
    held = 1'b0;
    result_stall = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (!held && items_sent >= HOLD_AFTER) begin
        stall_for = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        stall_for = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(6, 30);
      end
      free_for = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 150)
                                              : $urandom_range(1, 4);
      if (stall_for > 0) begin
        result_stall <= 1'b1;
        repeat (stall_for) @(negedge clk);
      end
      result_stall <= 1'b0;
      repeat (free_for) @(negedge clk);
    end
  end

  initial begin
    item_t      beat;
    logic [2:0] op;
    int         n;
    int         r;
    int         len;
    bit         filling;
    int         full_dwell;
    int         drain_floor;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    filling = 1'b1;
    full_dwell = 0;
    drain_floor = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty list corner cases.
    send_op(OP_READ, 0, 32'sd0);
    send_op(OP_REMOVE, 1, 32'sd0);
    send_op(OP_FIND, 0, 32'sd0);
    send_op(OP_REVERSE, 0, 32'sd0);
    send_op(OP_INSERT, 0, 32'sd5);
    send_op(OP_INSERT, 2, 32'sd5);
    // Build a short list through first, last and middle inserts.
    send_op(OP_INSERT, 1, 32'sh7FFF_FFFF);
    send_op(OP_REVERSE, 0, 32'sd0);
    send_op(OP_INSERT, 2, 32'sh8000_0000);
    send_op(OP_INSERT, 1, 32'sd0);
    send_op(OP_INSERT, 2, -32'sd1);
    send_op(OP_FIND, POS_MAX, -32'sd1);
    send_op(OP_FIND, 0, 32'sd12345);
    send_op(OP_REVERSE, POS_MAX, 32'sd0);
    send_op(OP_READ, 3, 32'sd0);
    send_op(OP_READ, 4, 32'sd0);
    send_op(OP_READ, POS_MAX, 32'sd0);
    send_op(OP_REMOVE, 5, 32'sd0);
    send_op(OP_REMOVE, 2, 32'sd0);
    send_op(OP_SPARE_FIRST, POS_MAX, -32'sd1);
    send_op(OP_SPARE_FIRST + 3'd1, 0, 32'sd7);
    send_op(OP_SPARE_LAST, POS_MAX, 32'sh8000_0000);
    send_op(OP_INSERT, POS_MAX, 32'sd9);
    send_op(OP_REMOVE, 1, 32'sd0);
    send_op(OP_FIND, 0, 32'sh8000_0000);

    // Random part: alternate between filling the list up to capacity and
    // draining it down to a few entries.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      len = list_len;
      if (filling && len == CAPACITY) begin
        full_dwell++;
        if (full_dwell > 6) begin
          filling = 1'b0;
          drain_floor = $urandom_range(0, 3);
        end
      end else if (!filling && len <= drain_floor) begin
        filling = 1'b1;
        full_dwell = 0;
      end
      r = $urandom_range(0, 99);
      if (r >= 95) op = 3'($urandom_range(int'(OP_SPARE_FIRST), int'(OP_SPARE_LAST)));
      else if (filling) op = (r < 60) ? OP_INSERT : (r < 70) ? OP_REMOVE :
                             (r < 82) ? OP_FIND : (r < 91) ? OP_READ : OP_REVERSE;
      else op = (r < 20) ? OP_INSERT : (r < 65) ? OP_REMOVE :
                (r < 80) ? OP_FIND : (r < 90) ? OP_READ : OP_REVERSE;
      beat.operation = op;
      beat.item_value = pick_value();
      beat.position = POS_W'($urandom_range(0, POS_MAX));
      case (op)
        OP_INSERT: begin
          if ($urandom_range(0, 9) != 0) beat.position = POS_W'($urandom_range(1, len + 1));
          else beat.position = bad_position(len + 2);
        end
        OP_REMOVE: begin
          if (len > 0 && $urandom_range(0, 9) != 0) begin
            beat.position = POS_W'($urandom_range(1, len));
          end else begin
            beat.position = bad_position(len + 1);
          end
        end
        OP_READ: begin
          if (len > 0 && $urandom_range(0, 9) != 0) begin
            beat.position = POS_W'($urandom_range(0, len - 1));
          end else begin
            beat.position = POS_W'($urandom_range(len, POS_MAX));
          end
        end
        default: begin
        end
      endcase
      send_item(beat);
    end
    item_valid <= 1'b0;

    wait (pending == 0);
    repeat (100) @(posedge clk);
    $display("%0d items: %0d insert, %0d remove, %0d find, %0d read, %0d reverse, %0d spare",
             items_sent, op_tally[OP_INSERT], op_tally[OP_REMOVE], op_tally[OP_FIND],
             op_tally[OP_READ], op_tally[OP_REVERSE],
             op_tally[5] + op_tally[6] + op_tally[7]);
    $display("inserts refused on a full list: %0d; one result hold-off of %0d cycles",
             full_count, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
